// ===== hdl/hds_pkg.sv =====
// Shared types and constants for the heat diffusion stencil step core.
package hds_pkg;

   localparam int MAX_COLUMNS_DEFAULT = 1024;

   localparam int TEMP_W   = 32;
   localparam int DIFF_W   = 16;
   localparam int GWIDTH_W = 11;
   localparam int GAIN_W   = 16;
   localparam int ROW_W    = 16;
   localparam int LAP_W    = TEMP_W + 3;
   localparam int PROD_W   = GAIN_W + 1 + LAP_W;
   localparam int FRAC_W   = 16;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [GWIDTH_W-1:0] GRID_WIDTH_RESET = GWIDTH_W'(1024);
   localparam logic [GAIN_W-1:0]   STEP_GAIN_RESET  = GAIN_W'(6554);
   localparam logic [ROW_W-1:0]    ROW_MAX          = '1;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_GAIN  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_MUL,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_issue;
      logic commit;
      logic multiply;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic produce;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/heat_diffusion_stencil_step_core.sv =====
// Top level of the five-point heat diffusion stencil step core.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: temperature, diffusivity; tuser: action, start
//   rsp      out  rsp_tvalid/rsp_tready  tdata: new temperature; tlast: end of row; tuser: frame
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// A word producing a result runs through load, line buffer read, stencil sum and
// gain product, gain-by-Laplacian multiply and saturate; a word without one stops after the stencil sum.
// The sequencer runs one word at a time through the line buffers.
// Reset clears the sequencer, counters and configuration; line buffers are not cleared.
// A new word is taken while a finished word waits in the output register.
module heat_diffusion_stencil_step_core #(
   parameter int MAX_COLUMNS = hds_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hds_pkg::REQ_DATA_W-1:0]    req_tdata,  // [31:0] temperature, [47:32] diffusivity
   input  logic [hds_pkg::REQ_USER_W-1:0]    req_tuser,  // [0] action, [1] frame_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hds_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [31:0] new_temperature
   output logic                              rsp_tlast,  // end_of_row
   output logic                              rsp_tuser,  // [0] end_of_frame
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hds_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [hds_pkg::GWIDTH_W-1:0] grid_width_ff;
   logic [hds_pkg::GAIN_W-1:0]   step_gain_ff;

   hds_pkg::cmd_type    cmd;
   hds_pkg::status_type status;

   logic signed [hds_pkg::TEMP_W-1:0] new_temp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= hds_pkg::GRID_WIDTH_RESET;
         step_gain_ff  <= hds_pkg::STEP_GAIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            hds_pkg::REG_GRID_WIDTH: grid_width_ff <= csr_data[hds_pkg::GWIDTH_W-1:0];
            hds_pkg::REG_STEP_GAIN:  step_gain_ff  <= csr_data[hds_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   hds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hds_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .grid_width       (grid_width_ff),
      .step_gain        (step_gain_ff),
      .in_action        (req_tuser[0]),
      .in_frame_start   (req_tuser[1]),
      .in_temperature   (signed'(req_tdata[31:0])),
      .in_diffusivity   (req_tdata[47:32]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_temperature  (new_temp),
      .rsp_end_of_row   (rsp_tlast),
      .rsp_end_of_frame (rsp_tuser)
   );

   assign rsp_tdata = new_temp;

endmodule

// ===== hdl/hds_ctrl.sv =====
// Sequencer for one word: load, read line buffers, commit, multiply, finish.
module hds_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  hds_pkg::status_type   status,
   output hds_pkg::cmd_type      cmd
);

   hds_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hds_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = hds_pkg::ST_READ;
         end
         hds_pkg::ST_READ: state_in = hds_pkg::ST_EXEC;
         hds_pkg::ST_EXEC: begin
            state_in = status.produce ? hds_pkg::ST_MUL : hds_pkg::ST_IDLE;
         end
         hds_pkg::ST_MUL: state_in = hds_pkg::ST_FIN;
         hds_pkg::ST_FIN: begin
            if (status.out_free) state_in = hds_pkg::ST_IDLE;
         end
         default: state_in = hds_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         hds_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         hds_pkg::ST_READ: cmd.rd_issue = 1'b1;
         hds_pkg::ST_EXEC: cmd.commit   = 1'b1;
         hds_pkg::ST_MUL:  cmd.multiply = 1'b1;
         // hold the result until the output register frees up
         hds_pkg::ST_FIN:  cmd.finish   = status.out_free;
         default: ;
      endcase
   end

endmodule

// ===== hdl/hds_datapath.sv =====
// Line buffers, counters, stencil arithmetic and output register.
module hds_datapath #(
   parameter int MAX_COLUMNS = hds_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hds_pkg::cmd_type                  cmd,
   output hds_pkg::status_type               status,
   input  logic [hds_pkg::GWIDTH_W-1:0]      grid_width,
   input  logic [hds_pkg::GAIN_W-1:0]        step_gain,
   input  logic                              in_action,
   input  logic                              in_frame_start,
   input  logic signed [hds_pkg::TEMP_W-1:0] in_temperature,
   input  logic [hds_pkg::DIFF_W-1:0]        in_diffusivity,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic signed [hds_pkg::TEMP_W-1:0] rsp_temperature,
   output logic                              rsp_end_of_row,
   output logic                              rsp_end_of_frame
);

   localparam int AW  = $clog2(MAX_COLUMNS);
   localparam int CW  = $clog2(MAX_COLUMNS + 1);
   localparam int MW  = (CW > hds_pkg::GWIDTH_W) ? CW : hds_pkg::GWIDTH_W;
   localparam int TW  = hds_pkg::TEMP_W;
   localparam int LW  = hds_pkg::LAP_W;
   localparam int PW  = hds_pkg::PROD_W;
   localparam int DW  = PW - hds_pkg::FRAC_W;
   localparam int SW  = DW + 1;
   localparam int RW  = hds_pkg::ROW_W;

   logic signed [TW-1:0]  upper_mem [MAX_COLUMNS];
   logic signed [TW-1:0]  middle_mem [MAX_COLUMNS];
   logic [hds_pkg::DIFF_W-1:0] diff_mem [MAX_COLUMNS];

   logic [AW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic signed [TW-1:0] hold_ff;

   logic                 drain_ff;
   logic signed [TW-1:0] temp_ff;
   logic [hds_pkg::DIFF_W-1:0] diff_ff;
   logic [AW-1:0] cur_col_ff;
   logic [RW-1:0] cur_row_ff;
   logic          last_ff;

   logic signed [TW-1:0] ctr_rd_ff, side_rd_ff, upper_rd_ff;
   logic [hds_pkg::DIFF_W-1:0] diff_rd_ff;

   logic [hds_pkg::GAIN_W-1:0] gain_ff;
   logic signed [LW-1:0] lap_ff;
   logic signed [TW-1:0] ctr_ff;
   logic                 eor_ff, eof_ff;
   logic signed [PW-1:0] prod_ff;

   logic                 rsp_valid_ff;
   logic signed [TW-1:0] rsp_temp_ff;
   logic                 rsp_eor_ff, rsp_eof_ff;

   logic [MW-1:0] gw_ext, m_used;
   logic [AW-1:0] m_last, col_base, col_eff;
   logic [RW-1:0] row_eff;
   logic [AW-1:0] side_addr;
   logic          row_zero, ignore_item;
   logic signed [TW-1:0] lft, rgt, top, bot;
   logic signed [LW-1:0] lap;
   logic [2*hds_pkg::GAIN_W-1:0] gain_full;
   logic signed [DW-1:0] delta;
   logic signed [SW-1:0] sum;
   logic signed [TW-1:0] sat_val;

   // clamp width and column counter for the word being loaded
   always_comb begin
      gw_ext = MW'(grid_width);
      if (gw_ext < MW'(3)) begin
         m_used = MW'(3);
      end else if (gw_ext > MW'(MAX_COLUMNS)) begin
         m_used = MW'(MAX_COLUMNS);
      end else begin
         m_used = gw_ext;
      end
      m_last   = AW'(m_used - MW'(1));
      col_base = in_frame_start ? '0 : col_ff;
      row_eff  = in_frame_start ? '0 : row_ff;
      col_eff  = (col_base > m_last) ? m_last : col_base;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         drain_ff   <= in_action;
         temp_ff    <= in_temperature;
         diff_ff    <= in_diffusivity;
         cur_col_ff <= col_eff;
         cur_row_ff <= row_eff;
         last_ff    <= (col_eff == m_last);
      end
   end

   // column 0 mirrors column 1; last column takes its neighbor from the hold
   always_comb begin
      if (cur_col_ff == '0) begin
         side_addr = AW'(1);
      end else if (last_ff) begin
         side_addr = cur_col_ff;
      end else begin
         side_addr = cur_col_ff + AW'(1);
      end
   end

   assign row_zero    = (cur_row_ff == '0);
   assign ignore_item = drain_ff && row_zero;

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         ctr_rd_ff   <= middle_mem[cur_col_ff];
         side_rd_ff  <= middle_mem[side_addr];
         upper_rd_ff <= upper_mem[cur_col_ff];
         diff_rd_ff  <= diff_mem[cur_col_ff];
      end
      if (cmd.commit && !drain_ff) begin
         middle_mem[cur_col_ff] <= temp_ff;
         diff_mem[cur_col_ff]   <= diff_ff;
         if (!row_zero) begin
            upper_mem[cur_col_ff] <= ctr_rd_ff;
         end
      end
   end

   always_comb begin
      lft = (cur_col_ff == '0) ? side_rd_ff : hold_ff;
      rgt = last_ff ? hold_ff : side_rd_ff;
      if (!drain_ff) begin
         bot = temp_ff;
         top = (cur_row_ff == RW'(1)) ? temp_ff : upper_rd_ff;
      end else if (cur_row_ff == RW'(1)) begin
         bot = ctr_rd_ff;
         top = ctr_rd_ff;
      end else begin
         bot = upper_rd_ff;
         top = upper_rd_ff;
      end
      lap = LW'(lft) + LW'(rgt) + LW'(top) + LW'(bot) - (LW'(ctr_rd_ff) <<< 2);
      gain_full = diff_rd_ff * step_gain;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         gain_ff <= gain_full[2*hds_pkg::GAIN_W-1:hds_pkg::FRAC_W];
         lap_ff  <= lap;
         ctr_ff  <= ctr_rd_ff;
         eor_ff  <= last_ff;
         eof_ff  <= drain_ff && last_ff;
      end
      if (cmd.multiply) begin
         prod_ff <= $signed({1'b0, gain_ff}) * lap_ff;
      end
   end

   // counters and the left-neighbor hold advance on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         hold_ff <= '0;
      end else if (cmd.commit) begin
         if (ignore_item) begin
            col_ff <= cur_col_ff;
            row_ff <= cur_row_ff;
         end else begin
            hold_ff <= ctr_rd_ff;
            if (last_ff) begin
               col_ff <= '0;
               if (drain_ff) begin
                  row_ff <= '0;
               end else if (cur_row_ff != hds_pkg::ROW_MAX) begin
                  row_ff <= cur_row_ff + RW'(1);
               end else begin
                  row_ff <= cur_row_ff;
               end
            end else begin
               col_ff <= cur_col_ff + AW'(1);
               row_ff <= cur_row_ff;
            end
         end
      end
   end

   always_comb begin
      delta = DW'(prod_ff >>> hds_pkg::FRAC_W);
      sum   = SW'(ctr_ff) + SW'(delta);
      if (sum > SW'(signed'({1'b0, {(TW-1){1'b1}}}))) begin
         sat_val = {1'b0, {(TW-1){1'b1}}};
      end else if (sum < -SW'(signed'({1'b0, {(TW-1){1'b1}}})) - SW'(1)) begin
         sat_val = {1'b1, {(TW-1){1'b0}}};
      end else begin
         sat_val = sum[TW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_temp_ff <= sat_val;
         rsp_eor_ff  <= eor_ff;
         rsp_eof_ff  <= eof_ff;
      end
   end

   assign status.produce  = !row_zero;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_temperature  = rsp_temp_ff;
   assign rsp_end_of_row   = rsp_eor_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the heat diffusion stencil step core.

typedef struct packed {
   logic [31:0] temp;
   logic        row_end;
   logic        frame_end;
} cell_update_type;

class diffusion_scoreboard;
   int unsigned     grid_width;
   int unsigned     step_gain;
   int              upper_row [hds_pkg::MAX_COLUMNS_DEFAULT];
   int              middle_row [hds_pkg::MAX_COLUMNS_DEFAULT];
   int unsigned     middle_diff [hds_pkg::MAX_COLUMNS_DEFAULT];
   bit              upper_written [hds_pkg::MAX_COLUMNS_DEFAULT];
   int unsigned     col_count;
   int unsigned     row_count;
   int              left_hold;
   cell_update_type pending[$];
   int              failures;
   int              reports;

   function new();
      grid_width = 32'(hds_pkg::GRID_WIDTH_RESET);
      step_gain  = 32'(hds_pkg::STEP_GAIN_RESET);
      col_count  = 0;
      row_count  = 0;
      left_hold  = 0;
      failures   = 0;
      reports    = 0;
   endfunction

   function void set_reg(logic [hds_pkg::CSR_IDX_W-1:0] idx,
                         logic [hds_pkg::CSR_DATA_W-1:0] value);
      if (idx == hds_pkg::REG_GRID_WIDTH)
         grid_width = 32'(value[hds_pkg::GWIDTH_W-1:0]);
      else if (idx == hds_pkg::REG_STEP_GAIN)
         step_gain = 32'(value);
   endfunction

   function int unsigned active_width();
      int unsigned m;
      m = grid_width;
      if (m < 3) m = 3;
      if (m > hds_pkg::MAX_COLUMNS_DEFAULT) m = hds_pkg::MAX_COLUMNS_DEFAULT;
      return m;
   endfunction

   // a drain in row 1 leaves the upper store untouched, so row 2 would read it
   function bit drain_safe();
      return row_count != 1 || upper_written[col_count];
   endfunction

   // returns 0 when the word is ignored
   function bit note_word(bit drain, bit start, logic [31:0] tin_raw, logic [15:0] din);
      int unsigned     m;
      int unsigned     c;
      bit              last;
      int              tin;
      longint          ctr, lft, rgt, top, bot, lap, gain, delta, sum;
      cell_update_type upd;
      m   = active_width();
      tin = $signed(tin_raw);
      if (start) begin
         row_count = 0;
         col_count = 0;
      end
      if (col_count > m - 1) col_count = m - 1;
      c    = col_count;
      last = (c == m - 1);

      if (row_count == 0) begin
         if (drain) return 0;
         left_hold      = middle_row[c];
         middle_row[c]  = tin;
         middle_diff[c] = 32'(din);
         if (last) begin
            col_count = 0;
            row_count = 1;
         end else begin
            col_count = c + 1;
         end
         return 1;
      end

      ctr = middle_row[c];
      lft = (c == 0) ? middle_row[1] : left_hold;
      rgt = last ? left_hold : middle_row[c + 1];
      if (!drain) begin
         bot = tin;
         top = (row_count == 1) ? tin : upper_row[c];
      end else if (row_count == 1) begin
         bot = ctr;
         top = ctr;
      end else begin
         bot = upper_row[c];
         top = upper_row[c];
      end
      lap   = lft + rgt + top + bot - 4 * ctr;
      gain  = (middle_diff[c] * step_gain) >> 16;
      delta = (gain * lap) >>> 16;
      sum   = ctr + delta;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;

      left_hold = middle_row[c];
      if (!drain) begin
         upper_row[c]     = middle_row[c];
         upper_written[c] = 1'b1;
         middle_row[c]    = tin;
         middle_diff[c]   = 32'(din);
      end

      upd.temp      = sum[31:0];
      upd.row_end   = last;
      upd.frame_end = drain && last;
      pending.push_back(upd);

      if (last) begin
         col_count = 0;
         if (drain)
            row_count = 0;
         else if (row_count < 16'hffff)
            row_count++;
      end else begin
         col_count = c + 1;
      end
      return 1;
   endfunction

   function void flag(string what, logic [31:0] exp_val, logic [31:0] got_val);
      failures++;
      if (reports < 100)
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_val, got_val);
      reports++;
   endfunction

   function void check_word(logic [31:0] temp, logic row_end, logic frame_end);
      cell_update_type upd;
      if (pending.size() == 0) begin
         flag("unexpected word", 32'h0, temp);
         return;
      end
      upd = pending.pop_front();
      if (temp !== upd.temp) flag("new_temperature", upd.temp, temp);
      if (row_end !== upd.row_end) flag("end_of_row", upd.row_end, row_end);
      if (frame_end !== upd.frame_end) flag("end_of_frame", upd.frame_end, frame_end);
   endfunction
endclass

module tb_top;

   localparam int RANDOM_WORDS  = 110;
   localparam int SETTLE_CYCLES = 16;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [hds_pkg::REQ_DATA_W-1:0]     req_tdata;
   logic [hds_pkg::REQ_USER_W-1:0]     req_tuser;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [hds_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                               rsp_tlast;
   logic                               rsp_tuser;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [hds_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [hds_pkg::CSR_DATA_W-1:0]     csr_data;

   diffusion_scoreboard sb = new();

   int burst_left = 0;
   int open_left  = 0;
   int stall_left = 0;
   int used_words = 0;

   heat_diffusion_stencil_step_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // receiver: open windows and stalls of random length, long open stretches now and then
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if (open_left > 0) begin
         rsp_tready = 1'b1;
         open_left--;
      end else begin
         rsp_tready = 1'b1;
         open_left  = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
         stall_left = $urandom_range(0, 8);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   function automatic logic [31:0] rand_temp();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'($urandom_range(0, 4095)) - 32'd2048;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] rand_diff();
      case ($urandom_range(0, 5))
         0: return 16'h0;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_word(input bit drain, input bit start,
                            input logic [31:0] temp, input logic [15:0] diff);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = {diff, temp};
      req_tuser  = {start, drain};
      do @(posedge clock); while (!req_tready);
      used_words += sb.note_word(drain, start, temp, diff);
   endtask

   task automatic hold_until_empty();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [hds_pkg::CSR_IDX_W-1:0] idx,
                            input logic [hds_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // wait out words still in flight that produce no result
   task automatic settle();
      hold_until_empty();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic reconfigure();
      logic [hds_pkg::CSR_DATA_W-1:0] width_val;
      logic [hds_pkg::CSR_DATA_W-1:0] gain_val;
      settle();
      case ($urandom_range(0, 9))
         0: width_val = 16'($urandom_range(0, 2));
         1, 2: width_val = 16'($urandom_range(9, 40));
         default: width_val = 16'($urandom_range(3, 8));
      endcase
      write_reg(hds_pkg::REG_GRID_WIDTH, width_val);
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 3))
            0: gain_val = 16'h0;
            1: gain_val = 16'hffff;
            2: gain_val = hds_pkg::STEP_GAIN_RESET;
            default: gain_val = 16'($urandom);
         endcase
         write_reg(hds_pkg::REG_STEP_GAIN, gain_val);
      end
   endtask

   task automatic run_random_frames();
      int unsigned rows_goal;
      int          base;
      bit          first;
      base = used_words;
      while (used_words - base < RANDOM_WORDS) begin
         if (used_words == base || $urandom_range(0, 2) == 0) reconfigure();
         rows_goal = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
         first = 1'b1;
         forever begin
            if ($urandom_range(0, 49) == 0) hold_until_empty();
            if (!first && sb.row_count >= rows_goal) begin
               send_word(1'b1, 1'b0, rand_temp(), rand_diff());
               if (sb.row_count == 0) break;
            end else if (!first && $urandom_range(0, 29) == 0 && sb.drain_safe()) begin
               send_word(1'b1, 1'b0, rand_temp(), rand_diff());
            end else if (!first && $urandom_range(0, 99) == 0) begin
               // restart the grid from the middle of a frame
               send_word(1'b0, 1'b1, rand_temp(), rand_diff());
            end else begin
               send_word(1'b0, first, rand_temp(), rand_diff());
               first = 1'b0;
            end
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-row grid at the narrowest width, saturating both ways
      write_reg(hds_pkg::REG_GRID_WIDTH, 16'd3);
      write_reg(hds_pkg::REG_STEP_GAIN, 16'hffff);
      send_word(1'b1, 1'b1, 32'h1234_5678, 16'h00ff);
      send_word(1'b0, 1'b1, 32'h7fff_ffff, 16'hffff);
      send_word(1'b0, 1'b0, 32'h8000_0000, 16'hffff);
      send_word(1'b0, 1'b0, 32'h7fff_ffff, 16'hffff);
      repeat (3) send_word(1'b1, 1'b0, 32'hffff_ffff, 16'hffff);

      // three rows, a drain mid-row, then narrow the grid under a column past the new edge
      settle();
      write_reg(hds_pkg::REG_GRID_WIDTH, 16'd4);
      write_reg(hds_pkg::REG_STEP_GAIN, 16'd40000);
      send_word(1'b0, 1'b1, 32'h0, 16'h0);
      send_word(1'b0, 1'b0, 32'h0001_0000, 16'hffff);
      send_word(1'b0, 1'b0, 32'hffff_0000, 16'h8000);
      send_word(1'b0, 1'b0, 32'h7fff_ffff, 16'h0001);
      repeat (4) send_word(1'b0, 1'b0, rand_temp(), rand_diff());
      send_word(1'b0, 1'b0, 32'h8000_0000, 16'hffff);
      send_word(1'b1, 1'b0, 32'h0, 16'h0);
      send_word(1'b0, 1'b0, 32'h0002_8000, 16'h4000);
      settle();
      write_reg(hds_pkg::REG_GRID_WIDTH, 16'd3);
      send_word(1'b1, 1'b0, 32'h0, 16'h0);

      // widest grid with the width clamped to the column limit, one row
      settle();
      write_reg(hds_pkg::REG_GRID_WIDTH, 16'd2047);
      write_reg(hds_pkg::REG_STEP_GAIN, hds_pkg::STEP_GAIN_RESET);
      for (int c = 0; c < hds_pkg::MAX_COLUMNS_DEFAULT; c++)
         send_word(1'b0, c == 0, rand_temp(), rand_diff());
      repeat (4) send_word(1'b1, 1'b0, rand_temp(), rand_diff());
      // narrow the grid so the next drain lands on the last column
      settle();
      write_reg(hds_pkg::REG_GRID_WIDTH, 16'd3);
      send_word(1'b1, 1'b0, 32'h0, 16'h0);

      run_random_frames();

      hold_until_empty();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #60000000;
      $display("simulation failed");
      $finish;
   end

endmodule
